/* hw/rtl/scm_pkg.sv */
package scm_pkg;

   // Fixed widths of the point fields and the result channels
   localparam int ValueWidth  = 32;
   localparam int ChanWidth   = 8;
   localparam int ColourWidth = 3 * ChanWidth;
   localparam int AddrWidth   = 5;
   localparam int DataWidth   = 32;
   localparam int ModeWidth   = 3;
   localparam int IndexWidth  = 3;

   // Colour source select codes
   localparam logic [ModeWidth-1:0] MODE_FLAT      = 3'd0;
   localparam logic [ModeWidth-1:0] MODE_INTENSITY = 3'd1;
   localparam logic [ModeWidth-1:0] MODE_RANGE     = 3'd2;
   localparam logic [ModeWidth-1:0] MODE_X         = 3'd3;
   localparam logic [ModeWidth-1:0] MODE_Y         = 3'd4;
   localparam logic [ModeWidth-1:0] MODE_Z         = 3'd5;

   // Register indexes (byte address is 4 * index)
   localparam logic [IndexWidth-1:0] REG_COLOUR_MODE    = 3'd0;
   localparam logic [IndexWidth-1:0] REG_LOW_BOUND      = 3'd1;
   localparam logic [IndexWidth-1:0] REG_HIGH_BOUND     = 3'd2;
   localparam logic [IndexWidth-1:0] REG_RAINBOW_ENABLE = 3'd3;
   localparam logic [IndexWidth-1:0] REG_LOW_COLOUR     = 3'd4;
   localparam logic [IndexWidth-1:0] REG_HIGH_COLOUR    = 3'd5;

   // Full-scale channel value of the hue wheel
   localparam logic [ChanWidth-1:0] Chroma = 8'd254;

   // floor(254 * f / 60) for f = 0 .. 60; the top entries are unused
   localparam logic [ChanWidth-1:0] RiseTable [64] = '{
      8'd0,   8'd4,   8'd8,   8'd12,  8'd16,  8'd21,  8'd25,  8'd29,
      8'd33,  8'd38,  8'd42,  8'd46,  8'd50,  8'd55,  8'd59,  8'd63,
      8'd67,  8'd71,  8'd76,  8'd80,  8'd84,  8'd88,  8'd93,  8'd97,
      8'd101, 8'd105, 8'd110, 8'd114, 8'd118, 8'd122, 8'd127, 8'd131,
      8'd135, 8'd139, 8'd143, 8'd148, 8'd152, 8'd156, 8'd160, 8'd165,
      8'd169, 8'd173, 8'd177, 8'd182, 8'd186, 8'd190, 8'd194, 8'd198,
      8'd203, 8'd207, 8'd211, 8'd215, 8'd220, 8'd224, 8'd228, 8'd232,
      8'd237, 8'd241, 8'd245, 8'd249, 8'd254, 8'd0,   8'd0,   8'd0
   };

   // Configuration as seen by the datapath
   typedef struct packed {
      logic [ModeWidth-1:0]          colour_mode;
      logic signed [ValueWidth-1:0]  low_bound;
      logic signed [ValueWidth-1:0]  high_bound;
      logic                          rainbow_enable;
      logic [ColourWidth-1:0]        low_colour;
      logic [ColourWidth-1:0]        high_colour;
      logic [ValueWidth-1:0]         divisor;
   } cfg_type;

   // Control bits that travel with each word
   typedef struct packed {
      logic valid;
      logic flat;
      logic use_div;
   } ctl_type;

   // Hue in degrees (0 .. 255) to packed RGB, full saturation, lightness 127
   function automatic logic [ColourWidth-1:0] hue_to_rgb(input logic [ChanWidth-1:0] h);
      logic [ChanWidth-1:0] f;
      logic [ChanWidth-1:0] down_idx;
      logic [ChanWidth-1:0] up;
      logic [ChanWidth-1:0] down;
      logic [ColourWidth-1:0] rgb;
      if (h < 8'd60) begin
         f = h;
      end else if (h < 8'd120) begin
         f = h - 8'd60;
      end else if (h < 8'd180) begin
         f = h - 8'd120;
      end else if (h < 8'd240) begin
         f = h - 8'd180;
      end else begin
         f = h - 8'd240;
      end
      down_idx = 8'd60 - f;
      up       = RiseTable[f[5:0]];
      down     = RiseTable[down_idx[5:0]];
      if (h < 8'd60) begin
         rgb = {Chroma, up, 8'd0};
      end else if (h < 8'd120) begin
         rgb = {down, Chroma, 8'd0};
      end else if (h < 8'd180) begin
         rgb = {8'd0, Chroma, up};
      end else if (h < 8'd240) begin
         rgb = {8'd0, down, Chroma};
      end else begin
         rgb = {up, 8'd0, Chroma};
      end
      return rgb;
   endfunction

endpackage

/* hw/rtl/scm_csr.sv */
module scm_csr
   import scm_pkg::*;
#(
   parameter int FRACTION_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [AddrWidth-1:0] csr_paddr,
   input  logic [DataWidth-1:0] csr_pwdata,
   output logic [DataWidth-1:0] csr_prdata,
   output logic                 csr_pready,
   output cfg_type              cfg
);

   localparam logic signed [ValueWidth-1:0] HighReset =
      ValueWidth'(100) << FRACTION_BITS;

   logic [ModeWidth-1:0]         mode_ff;
   logic signed [ValueWidth-1:0] low_ff;
   logic signed [ValueWidth-1:0] high_ff;
   logic                         rainbow_ff;
   logic [ColourWidth-1:0]       low_colour_ff;
   logic [ColourWidth-1:0]       high_colour_ff;
   logic [ValueWidth-1:0]        divisor_ff;
   logic [ValueWidth-1:0]        divisor_in;
   logic                         write_en;
   logic [IndexWidth-1:0]        index;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign index      = csr_paddr[AddrWidth-1:2];

   // Update the addressed register on the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_FLAT;
         low_ff         <= '0;
         high_ff        <= HighReset;
         rainbow_ff     <= 1'b0;
         low_colour_ff  <= '1;
         high_colour_ff <= '0;
      end else if (write_en) begin
         unique case (index)
            REG_COLOUR_MODE:    mode_ff        <= csr_pwdata[ModeWidth-1:0];
            REG_LOW_BOUND:      low_ff         <= csr_pwdata;
            REG_HIGH_BOUND:     high_ff        <= csr_pwdata;
            REG_RAINBOW_ENABLE: rainbow_ff     <= csr_pwdata[0];
            REG_LOW_COLOUR:     low_colour_ff  <= csr_pwdata[ColourWidth-1:0];
            REG_HIGH_COLOUR:    high_colour_ff <= csr_pwdata[ColourWidth-1:0];
            default: ;
         endcase
      end
   end

   // Keep the span of the bounds ready for the divider
   assign divisor_in = high_ff - low_ff;

   always_ff @(posedge clock) begin
      divisor_ff <= divisor_in;
   end

   // Read back
   always_comb begin
      unique case (index)
         REG_COLOUR_MODE:    csr_prdata = DataWidth'(mode_ff);
         REG_LOW_BOUND:      csr_prdata = low_ff;
         REG_HIGH_BOUND:     csr_prdata = high_ff;
         REG_RAINBOW_ENABLE: csr_prdata = DataWidth'(rainbow_ff);
         REG_LOW_COLOUR:     csr_prdata = DataWidth'(low_colour_ff);
         REG_HIGH_COLOUR:    csr_prdata = DataWidth'(high_colour_ff);
         default:            csr_prdata = '0;
      endcase
   end

   assign cfg.colour_mode    = mode_ff;
   assign cfg.low_bound      = low_ff;
   assign cfg.high_bound     = high_ff;
   assign cfg.rainbow_enable = rainbow_ff;
   assign cfg.low_colour     = low_colour_ff;
   assign cfg.high_colour    = high_colour_ff;
   assign cfg.divisor        = divisor_ff;

endmodule

/* hw/rtl/scm_front.sv */
module scm_front
   import scm_pkg::*;
#(
   parameter int FRACTION_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  cfg_type                      cfg,
   input  logic                         req_valid,
   input  logic signed [ValueWidth-1:0] req_range_value,
   input  logic signed [ValueWidth-1:0] req_intensity_value,
   input  logic signed [ValueWidth-1:0] req_x_value,
   input  logic signed [ValueWidth-1:0] req_y_value,
   input  logic signed [ValueWidth-1:0] req_z_value,
   input  logic                         req_intensity_present,
   output ctl_type                      ctl_out,
   output logic [ValueWidth-1:0]        rem_out,
   output logic [FRACTION_BITS:0]       t_out
);

   localparam int TW = FRACTION_BITS + 1;
   localparam logic signed [ValueWidth-1:0] OneValue = ValueWidth'(1) << FRACTION_BITS;

   // Stage 1: capture the point
   logic                         s1_valid_ff;
   logic signed [ValueWidth-1:0] s1_range_ff;
   logic signed [ValueWidth-1:0] s1_intensity_ff;
   logic signed [ValueWidth-1:0] s1_x_ff;
   logic signed [ValueWidth-1:0] s1_y_ff;
   logic signed [ValueWidth-1:0] s1_z_ff;
   logic                         s1_present_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_range_ff     <= req_range_value;
         s1_intensity_ff <= req_intensity_value;
         s1_x_ff         <= req_x_value;
         s1_y_ff         <= req_y_value;
         s1_z_ff         <= req_z_value;
         s1_present_ff   <= req_intensity_present;
      end
   end

   // Stage 2: pick the value to colour by
   logic                         s2_valid_ff;
   logic                         s2_flat_ff;
   logic signed [ValueWidth-1:0] s2_value_ff;
   logic                         s2_flat_in;
   logic signed [ValueWidth-1:0] s2_value_in;

   always_comb begin
      s2_flat_in  = 1'b0;
      s2_value_in = '0;
      case (cfg.colour_mode)
         MODE_INTENSITY: begin
            s2_value_in = s1_intensity_ff;
            s2_flat_in  = ~s1_present_ff;
         end
         MODE_RANGE: s2_value_in = s1_range_ff;
         MODE_X:     s2_value_in = s1_x_ff;
         MODE_Y:     s2_value_in = s1_y_ff;
         MODE_Z:     s2_value_in = s1_z_ff;
         default:    s2_flat_in  = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_flat_ff  <= s2_flat_in;
         s2_value_ff <= s2_value_in;
      end
   end

   // Stage 3: offset from the low bound and clamp decisions
   logic signed [ValueWidth:0] offset;
   logic                       bounds_ok;
   logic                       at_low;
   logic                       at_high;
   ctl_type                    s3_ctl_ff;
   ctl_type                    s3_ctl_in;
   logic [ValueWidth-1:0]      s3_rem_ff;
   logic [TW-1:0]              s3_t_ff;
   logic [TW-1:0]              s3_t_in;

   assign offset    = {s2_value_ff[ValueWidth-1], s2_value_ff}
                    - {cfg.low_bound[ValueWidth-1], cfg.low_bound};
   assign bounds_ok = cfg.high_bound > cfg.low_bound;
   assign at_low    = bounds_ok ? (s2_value_ff <= cfg.low_bound) : (s2_value_ff <= 0);
   assign at_high   = bounds_ok ? (s2_value_ff >= cfg.high_bound) : (s2_value_ff >= OneValue);

   always_comb begin
      s3_ctl_in.valid   = s2_valid_ff;
      s3_ctl_in.flat    = s2_flat_ff;
      s3_ctl_in.use_div = bounds_ok & ~at_low & ~at_high;
      if (at_low) begin
         s3_t_in = '0;
      end else if (at_high) begin
         s3_t_in = TW'(1) << FRACTION_BITS;
      end else begin
         s3_t_in = s2_value_ff[TW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ctl_ff <= '0;
      end else if (advance) begin
         s3_ctl_ff <= s3_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_rem_ff <= offset[ValueWidth-1:0];
         s3_t_ff   <= s3_t_in;
      end
   end

   assign ctl_out = s3_ctl_ff;
   assign rem_out = s3_rem_ff;
   assign t_out   = s3_t_ff;

endmodule

/* hw/rtl/scm_divider.sv */
module scm_divider
   import scm_pkg::*;
#(
   parameter int FRACTION_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic [ValueWidth-1:0]    divisor,
   input  ctl_type                  ctl_in,
   input  logic [ValueWidth-1:0]    rem_in,
   input  logic [FRACTION_BITS:0]   t_in,
   output ctl_type                  ctl_out,
   output logic [FRACTION_BITS-1:0] q_out,
   output logic [FRACTION_BITS:0]   t_out
);

   localparam int F  = FRACTION_BITS;
   localparam int TW = FRACTION_BITS + 1;

   // One quotient bit per stage, restoring form, MSB first
   ctl_type               ctl_ff [F];
   logic [ValueWidth-1:0] rem_ff [F];
   logic [F-1:0]          q_ff   [F];
   logic [TW-1:0]         t_ff   [F];

   ctl_type               ctl_src [F];
   logic [ValueWidth-1:0] rem_src [F];
   logic [F-1:0]          q_src   [F];
   logic [TW-1:0]         t_src   [F];

   for (genvar i = 0; i < F; i++) begin : g_stage
      logic [ValueWidth:0]   shifted;
      logic                  fits;
      logic [ValueWidth:0]   diff;
      logic [ValueWidth-1:0] rem_in_s;
      logic [F-1:0]          q_in_s;

      if (i == 0) begin : g_first
         assign ctl_src[i] = ctl_in;
         assign rem_src[i] = rem_in;
         assign q_src[i]   = '0;
         assign t_src[i]   = t_in;
      end else begin : g_next
         assign ctl_src[i] = ctl_ff[i-1];
         assign rem_src[i] = rem_ff[i-1];
         assign q_src[i]   = q_ff[i-1];
         assign t_src[i]   = t_ff[i-1];
      end

      // Shift, trial subtract, keep the difference if it fits
      assign shifted  = {rem_src[i], 1'b0};
      assign diff     = shifted - {1'b0, divisor};
      assign fits     = shifted >= {1'b0, divisor};
      assign rem_in_s = fits ? diff[ValueWidth-1:0] : shifted[ValueWidth-1:0];
      assign q_in_s   = {q_src[i][F-2:0], fits};

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[i] <= '0;
         end else if (advance) begin
            ctl_ff[i] <= ctl_src[i];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[i] <= rem_in_s;
            q_ff[i]   <= q_in_s;
            t_ff[i]   <= t_src[i];
         end
      end
   end

   assign ctl_out = ctl_ff[F-1];
   assign q_out   = q_ff[F-1];
   assign t_out   = t_ff[F-1];

endmodule

/* hw/rtl/scm_colour.sv */
module scm_colour
   import scm_pkg::*;
#(
   parameter int FRACTION_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  cfg_type                  cfg,
   input  ctl_type                  ctl_in,
   input  logic [FRACTION_BITS-1:0] q_in,
   input  logic [FRACTION_BITS:0]   t_in,
   output logic                     rsp_valid,
   output logic [ChanWidth-1:0]     rsp_red,
   output logic [ChanWidth-1:0]     rsp_green,
   output logic [ChanWidth-1:0]     rsp_blue
);

   localparam int F  = FRACTION_BITS;
   localparam int TW = FRACTION_BITS + 1;
   localparam int PW = TW + ChanWidth;

   // Stage A: final t, hue angle and blend products
   logic [TW-1:0]  t;
   logic [TW-1:0]  t_rest;
   logic [PW-1:0]  t_scaled;
   logic [PW-1:0]  hi_prod_in [3];
   logic [PW-1:0]  lo_prod_in [3];
   logic [PW-1:0]  hi_prod_ff [3];
   logic [PW-1:0]  lo_prod_ff [3];
   logic [ChanWidth-1:0] hue_ff;
   logic                 a_valid_ff;
   logic                 a_flat_ff;

   assign t        = ctl_in.use_div ? {1'b0, q_in} : t_in;
   assign t_rest   = (TW'(1) << F) - t;
   assign t_scaled = {t, {ChanWidth{1'b0}}} - PW'(t);

   for (genvar c = 0; c < 3; c++) begin : g_chan
      localparam int Lsb = ChanWidth * (2 - c);
      assign hi_prod_in[c] = PW'(t) * PW'(cfg.high_colour[Lsb +: ChanWidth]);
      assign lo_prod_in[c] = PW'(t_rest) * PW'(cfg.low_colour[Lsb +: ChanWidth]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= ctl_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_flat_ff  <= ctl_in.flat;
         hue_ff     <= t_scaled[F+ChanWidth-1:F];
         hi_prod_ff <= hi_prod_in;
         lo_prod_ff <= lo_prod_in;
      end
   end

   // Stage B: sum the blend, look up the hue, pick the colour
   logic [ColourWidth-1:0] blend_rgb;
   logic [ColourWidth-1:0] out_rgb_in;
   logic [ColourWidth-1:0] out_rgb_ff;
   logic                   out_valid_ff;

   for (genvar c = 0; c < 3; c++) begin : g_sum
      localparam int Lsb = ChanWidth * (2 - c);
      logic [PW-1:0] total;
      assign total = hi_prod_ff[c] + lo_prod_ff[c];
      assign blend_rgb[Lsb +: ChanWidth] = total[F+ChanWidth-1:F];
   end

   always_comb begin
      if (a_flat_ff) begin
         out_rgb_in = cfg.low_colour;
      end else if (cfg.rainbow_enable) begin
         out_rgb_in = hue_to_rgb(hue_ff);
      end else begin
         out_rgb_in = blend_rgb;
      end
   end

   // Output register: hold while the receiver stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_rgb_ff <= out_rgb_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_red   = out_rgb_ff[2*ChanWidth +: ChanWidth];
   assign rsp_green = out_rgb_ff[ChanWidth +: ChanWidth];
   assign rsp_blue  = out_rgb_ff[0 +: ChanWidth];

endmodule

/* hw/rtl/scalar_to_colour_map_core.sv */
// Colours one scan point per word: the configured mode picks range, intensity,
// x, y or z (flat mode, an unused mode, or intensity mode on a scan without
// intensity, returns the low colour), the value is scaled between the low and
// high bounds (raw when high is not above low) and clamped to [0, 1], and
// either blended between the two colours or turned into a hue on the HSL
// wheel. A new point is taken every cycle unless the pipe holds; the restoring
// divider produces one bit of the scaled value per stage. While a valid result
// is held by the receiver, the whole pipe holds and the input side is stalled.
// Registers (APB, byte address 4 * index): 0 colour_mode, 1 low_bound,
// 2 high_bound, 3 rainbow_enable, 4 low_colour, 5 high_colour; write them only
// while no points are in flight.
module scalar_to_colour_map_core
   import scm_pkg::*;
#(
   parameter int FRACTION_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [ValueWidth-1:0] req_range_value,
   input  logic signed [ValueWidth-1:0] req_intensity_value,
   input  logic signed [ValueWidth-1:0] req_x_value,
   input  logic signed [ValueWidth-1:0] req_y_value,
   input  logic signed [ValueWidth-1:0] req_z_value,
   input  logic                         req_intensity_present,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [ChanWidth-1:0]         rsp_red,
   output logic [ChanWidth-1:0]         rsp_green,
   output logic [ChanWidth-1:0]         rsp_blue,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [AddrWidth-1:0]         csr_paddr,
   input  logic [DataWidth-1:0]         csr_pwdata,
   output logic [DataWidth-1:0]         csr_prdata,
   output logic                         csr_pready
);

   cfg_type                  cfg;
   logic                     advance;
   ctl_type                  front_ctl;
   logic [ValueWidth-1:0]    front_rem;
   logic [FRACTION_BITS:0]   front_t;
   ctl_type                  div_ctl;
   logic [FRACTION_BITS-1:0] div_q;
   logic [FRACTION_BITS:0]   div_t;

   // Move the whole pipe unless a finished word is waiting on the receiver
   assign advance   = ~(rsp_valid & rsp_stall);
   assign req_stall = ~advance;

   scm_csr #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready),
      .cfg        (cfg)
   );

   scm_front #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_front (
      .clock                (clock),
      .reset                (reset),
      .advance              (advance),
      .cfg                  (cfg),
      .req_valid            (req_valid),
      .req_range_value      (req_range_value),
      .req_intensity_value  (req_intensity_value),
      .req_x_value          (req_x_value),
      .req_y_value          (req_y_value),
      .req_z_value          (req_z_value),
      .req_intensity_present(req_intensity_present),
      .ctl_out              (front_ctl),
      .rem_out              (front_rem),
      .t_out                (front_t)
   );

   scm_divider #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_divider (
      .clock  (clock),
      .reset  (reset),
      .advance(advance),
      .divisor(cfg.divisor),
      .ctl_in (front_ctl),
      .rem_in (front_rem),
      .t_in   (front_t),
      .ctl_out(div_ctl),
      .q_out  (div_q),
      .t_out  (div_t)
   );

   scm_colour #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_colour (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .cfg      (cfg),
      .ctl_in   (div_ctl),
      .q_in     (div_q),
      .t_in     (div_t),
      .rsp_valid(rsp_valid),
      .rsp_red  (rsp_red),
      .rsp_green(rsp_green),
      .rsp_blue (rsp_blue)
   );

endmodule

/* tb/testbench.sv */
module testbench;
   import scm_pkg::*;

   localparam int FracBits = 16;
   localparam int HueSector = 60;
   localparam int HueSpan = 255;
   localparam int ItemTarget = 850;
   localparam int PipeDepth = FracBits + 5;
   localparam longint MaxValue = 64'sd2147483647;
   localparam longint MinValue = -64'sd2147483648;
   localparam longint UnitValue = longint'(1) <<< FracBits;
   localparam logic [ModeWidth-1:0] ModeSpareLo = MODE_Z + 3'd1;
   localparam logic [ModeWidth-1:0] ModeSpareHi = MODE_Z + 3'd2;
   localparam logic [IndexWidth-1:0] RegSpareLo = REG_HIGH_COLOUR + 3'd1;
   localparam logic [IndexWidth-1:0] RegSpareHi = REG_HIGH_COLOUR + 3'd2;

   typedef struct packed {
      logic signed [ValueWidth-1:0] range_v;
      logic signed [ValueWidth-1:0] intensity_v;
      logic signed [ValueWidth-1:0] x_v;
      logic signed [ValueWidth-1:0] y_v;
      logic signed [ValueWidth-1:0] z_v;
      logic                         present;
   } scan_point_type;

   // Colour predictor with its own register copy and a queue of expected colours
   class colour_scoreboard;
      logic [ModeWidth-1:0]   mode;
      longint                 lo_bound;
      longint                 hi_bound;
      logic                   rainbow;
      logic [ColourWidth-1:0] lo_colour;
      logic [ColourWidth-1:0] hi_colour;
      logic [ColourWidth-1:0] expected_colours[$];
      int                     errors;

      function new();
         mode      = MODE_FLAT;
         lo_bound  = 0;
         hi_bound  = longint'(100) <<< FracBits;
         rainbow   = 1'b0;
         lo_colour = 24'hFFFFFF;
         hi_colour = 24'h000000;
         errors    = 0;
      endfunction

      function void write_reg(input logic [IndexWidth-1:0] idx, input logic [DataWidth-1:0] data);
         case (idx)
            REG_COLOUR_MODE:    mode      = data[ModeWidth-1:0];
            REG_LOW_BOUND:      lo_bound  = longint'($signed(data));
            REG_HIGH_BOUND:     hi_bound  = longint'($signed(data));
            REG_RAINBOW_ENABLE: rainbow   = data[0];
            REG_LOW_COLOUR:     lo_colour = data[ColourWidth-1:0];
            REG_HIGH_COLOUR:    hi_colour = data[ColourWidth-1:0];
            default: ;
         endcase
      endfunction

      // Scale between the bounds, or take the raw value when they are empty
      function longint unit_scale(input longint v);
         if (hi_bound > lo_bound) begin
            if (v <= lo_bound) return 0;
            if (v >= hi_bound) return UnitValue;
            return ((v - lo_bound) <<< FracBits) / (hi_bound - lo_bound);
         end
         if (v <= 0) return 0;
         if (v >= UnitValue) return UnitValue;
         return v;
      endfunction

      function logic [ChanWidth-1:0] mix(input longint t, input logic [ChanWidth-1:0] a,
                                         input logic [ChanWidth-1:0] b);
         return ChanWidth'((t * longint'(b) + (UnitValue - t) * longint'(a)) >>> FracBits);
      endfunction

      function logic [ColourWidth-1:0] hue_colour(input int h);
         int sector;
         int f;
         logic [ChanWidth-1:0] up;
         logic [ChanWidth-1:0] down;
         sector = h / HueSector;
         f      = h % HueSector;
         up     = ChanWidth'((Chroma * f) / HueSector);
         down   = ChanWidth'((Chroma * (HueSector - f)) / HueSector);
         case (sector)
            0: return {Chroma, up, 8'd0};
            1: return {down, Chroma, 8'd0};
            2: return {8'd0, Chroma, up};
            3: return {8'd0, down, Chroma};
            default: return {up, 8'd0, Chroma};
         endcase
      endfunction

      function logic [ColourWidth-1:0] map_colour(input scan_point_type p);
         longint v;
         longint t;
         logic   flat;
         flat = 1'b0;
         v    = 0;
         case (mode)
            MODE_INTENSITY: begin
               if (p.present) v = p.intensity_v;
               else flat = 1'b1;
            end
            MODE_RANGE: v = p.range_v;
            MODE_X:     v = p.x_v;
            MODE_Y:     v = p.y_v;
            MODE_Z:     v = p.z_v;
            default:    flat = 1'b1;
         endcase
         if (flat) return lo_colour;
         t = unit_scale(v);
         if (rainbow) return hue_colour(int'((t * HueSpan) >>> FracBits));
         return {mix(t, lo_colour[23:16], hi_colour[23:16]),
                 mix(t, lo_colour[15:8], hi_colour[15:8]),
                 mix(t, lo_colour[7:0], hi_colour[7:0])};
      endfunction

      function void note_point(input scan_point_type p);
         expected_colours = {expected_colours, map_colour(p)};
      endfunction

      function void check_colour(input logic [ColourWidth-1:0] got);
         string names[3];
         logic [ColourWidth-1:0] want;
         names = '{"blue", "green", "red"};
         if (expected_colours.size() == 0) begin
            errors++;
            $display("%0t: colour %h with no point outstanding", $time, got);
            return;
         end
         want = expected_colours[0];
         expected_colours.delete(0);
         for (int c = 0; c < 3; c++) begin
            if (want[8*c +: 8] !== got[8*c +: 8]) begin
               errors++;
               $display("%0t: %s expected %02h actual %02h", $time, names[c],
                        want[8*c +: 8], got[8*c +: 8]);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [ValueWidth-1:0] req_range_value = '0;
   logic signed [ValueWidth-1:0] req_intensity_value = '0;
   logic signed [ValueWidth-1:0] req_x_value = '0;
   logic signed [ValueWidth-1:0] req_y_value = '0;
   logic signed [ValueWidth-1:0] req_z_value = '0;
   logic req_intensity_present = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [ChanWidth-1:0] rsp_red;
   logic [ChanWidth-1:0] rsp_green;
   logic [ChanWidth-1:0] rsp_blue;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [AddrWidth-1:0] csr_paddr = '0;
   logic [DataWidth-1:0] csr_pwdata = '0;
   logic [DataWidth-1:0] csr_prdata;
   logic csr_pready;

   colour_scoreboard sb;
   int burst_left = 0;
   int stall_mode = 0;
   int stall_left = 0;

   scalar_to_colour_map_core #(.FRACTION_BITS(FracBits)) dut (.*);

   always #2 clock = ~clock;

   // Receiver: switch between stall patterns every so often
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(16, 160);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= stall_left[2];
      endcase
   end

   // Note accepted points and check accepted colours
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_point(scan_point_type'({req_range_value, req_intensity_value, req_x_value,
                                            req_y_value, req_z_value, req_intensity_present}));
         if (rsp_valid && !rsp_stall) sb.check_colour({rsp_red, rsp_green, rsp_blue});
      end
   end

   task automatic csr_write(input logic [IndexWidth-1:0] idx, input logic [DataWidth-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= AddrWidth'({idx, 2'b00});
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.write_reg(idx, data);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_config(input logic [ModeWidth-1:0] mode, input longint lo, input longint hi,
                               input logic rb, input logic [ColourWidth-1:0] lc,
                               input logic [ColourWidth-1:0] hc);
      csr_write(REG_COLOUR_MODE, DataWidth'(mode));
      csr_write(REG_LOW_BOUND, DataWidth'(lo));
      csr_write(REG_HIGH_BOUND, DataWidth'(hi));
      csr_write(REG_RAINBOW_ENABLE, DataWidth'(rb));
      csr_write(REG_LOW_COLOUR, DataWidth'(lc));
      csr_write(REG_HIGH_COLOUR, DataWidth'(hc));
   endtask

   // Drop valid and hold until every point in flight has come back
   task automatic await_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_colours.size() != 0) @(posedge clock);
   endtask

   // Send one word; open a new burst with a random gap when the last one ran out
   task automatic send_point(input scan_point_type p);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if ($urandom_range(0, 15) == 0) gap = 30;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid             <= 1'b1;
      req_range_value       <= p.range_v;
      req_intensity_value   <= p.intensity_v;
      req_x_value           <= p.x_v;
      req_y_value           <= p.y_v;
      req_z_value           <= p.z_v;
      req_intensity_present <= p.present;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Random point with the field that the mode selects set to v
   function automatic scan_point_type make_point(input logic [ModeWidth-1:0] mode,
                                                 input logic [ValueWidth-1:0] v,
                                                 input logic present);
      scan_point_type p;
      p = scan_point_type'({$urandom, $urandom, $urandom, $urandom, $urandom, 1'b0});
      p.present = present;
      case (mode)
         MODE_INTENSITY: p.intensity_v = v;
         MODE_RANGE:     p.range_v = v;
         MODE_X:         p.x_v = v;
         MODE_Y:         p.y_v = v;
         MODE_Z:         p.z_v = v;
         default: ;
      endcase
      return p;
   endfunction

   // Mostly values between the bounds, some on their edges, the rest anywhere
   function automatic logic [ValueWidth-1:0] pick_value(input longint lo, input longint hi);
      int pick;
      longint unsigned span;
      longint unsigned r64;
      pick = $urandom_range(0, 9);
      r64  = {$urandom, $urandom};
      if (hi <= lo) begin
         lo = 0;
         hi = UnitValue;
      end
      span = longint'(hi - lo) + 1;
      if (pick < 6) return ValueWidth'(lo + longint'(r64 % span));
      if (pick < 8) begin
         case ($urandom_range(0, 3))
            0: return ValueWidth'(lo);
            1: return ValueWidth'(hi);
            2: return ValueWidth'(lo - 1);
            default: return ValueWidth'(hi + 1);
         endcase
      end
      return $urandom;
   endfunction

   initial begin
      int hue_marks[10];
      longint hue_t;
      longint lo;
      longint hi;
      logic [ModeWidth-1:0] mode;
      logic [ColourWidth-1:0] lc;
      logic [ColourWidth-1:0] hc;
      int n;
      int sent;
      hue_marks = '{0, 59, 60, 119, 120, 179, 180, 239, 240, 255};
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Registers straight out of reset: flat mode gives white
      send_point(make_point(MODE_FLAT, $urandom, 1'b1));
      await_idle();

      // Intensity blend, with and without intensity in the scan
      apply_config(MODE_INTENSITY, 0, longint'(100) <<< FracBits, 1'b0, 24'h102030, 24'hF0E0D0);
      csr_write(RegSpareLo, $urandom);
      csr_write(RegSpareHi, $urandom);
      send_point(make_point(MODE_INTENSITY, 32'h0032_0000, 1'b0));
      send_point(make_point(MODE_INTENSITY, 32'hFFFF_FFFF, 1'b1));
      send_point(make_point(MODE_INTENSITY, 32'h0000_0000, 1'b1));
      send_point(make_point(MODE_INTENSITY, 32'h0032_0000, 1'b1));
      send_point(make_point(MODE_INTENSITY, 32'h0063_FFFF, 1'b1));
      send_point(make_point(MODE_INTENSITY, 32'h0064_0000, 1'b1));
      send_point(make_point(MODE_INTENSITY, 32'h7FFF_FFFF, 1'b1));
      send_point(make_point(MODE_INTENSITY, 32'h8000_0000, 1'b1));
      await_idle();

      // Unused modes act as flat
      apply_config(ModeSpareLo, 0, UnitValue, 1'b1, 24'hA5C35A, 24'h0F0F0F);
      send_point(make_point(MODE_RANGE, $urandom, 1'b1));
      await_idle();
      apply_config(ModeSpareHi, 0, UnitValue, 1'b0, 24'h3C7E81, 24'hFFFFFF);
      send_point(make_point(MODE_RANGE, $urandom, 1'b1));
      await_idle();

      // Hue wheel on raw values (equal bounds), hitting each sector edge
      apply_config(MODE_RANGE, 0, 0, 1'b1, 24'h000000, 24'hFFFFFF);
      foreach (hue_marks[i]) begin
         hue_t = (longint'(hue_marks[i]) * UnitValue + HueSpan - 1) / HueSpan;
         if (hue_marks[i] == 0) hue_t = -longint'($urandom_range(1, 1000));
         send_point(make_point(MODE_RANGE, ValueWidth'(hue_t), 1'b1));
      end
      await_idle();

      // Widest bounds
      apply_config(MODE_X, MinValue, MaxValue, 1'b0, 24'h000000, 24'hFFFFFF);
      send_point(make_point(MODE_X, 32'h8000_0000, 1'b0));
      send_point(make_point(MODE_X, 32'h7FFF_FFFF, 1'b0));
      send_point(make_point(MODE_X, 32'h0000_0000, 1'b0));
      await_idle();

      // Reversed bounds with the hue wheel, then equal bounds with the blend
      apply_config(MODE_Y, 100, -100, 1'b1, 24'hFFFFFF, 24'h000000);
      send_point(make_point(MODE_Y, 32'd1000, 1'b1));
      await_idle();
      apply_config(MODE_Z, longint'(5) <<< FracBits, longint'(5) <<< FracBits, 1'b0,
                   24'h123456, 24'hFEDCBA);
      send_point(make_point(MODE_Z, 32'd70000, 1'b1));
      await_idle();

      // Random phases: fresh registers, then a run of points aimed at the bounds
      sent = 0;
      while (sent < ItemTarget) begin
         case ($urandom_range(0, 9))
            0: mode = MODE_FLAT;
            1: mode = ModeWidth'($urandom_range(ModeSpareLo, ModeSpareHi));
            default: mode = ModeWidth'($urandom_range(MODE_INTENSITY, MODE_Z));
         endcase
         case ($urandom_range(0, 5))
            0, 1: begin
               lo = longint'($signed($urandom)) >>> $urandom_range(4, 24);
               hi = lo + longint'($urandom >> $urandom_range(0, 31)) + 1;
            end
            2: begin
               lo = MinValue;
               hi = MaxValue;
            end
            3: begin
               lo = longint'($signed($urandom));
               hi = lo + $urandom_range(1, 4);
            end
            4: begin
               lo = longint'($signed($urandom)) >>> 8;
               hi = lo - $urandom_range(0, 4096);
            end
            default: begin
               lo = longint'($signed($urandom));
               hi = longint'($signed($urandom));
            end
         endcase
         if (hi > MaxValue) hi = MaxValue;
         if (hi < MinValue) hi = MinValue;
         lc = ($urandom_range(0, 4) == 0) ? {ColourWidth{$urandom_range(0, 1) == 1}}
                                          : ColourWidth'($urandom);
         hc = ($urandom_range(0, 4) == 0) ? {ColourWidth{$urandom_range(0, 1) == 1}}
                                          : ColourWidth'($urandom);
         apply_config(mode, lo, hi, 1'($urandom_range(0, 1)), lc, hc);
         n = $urandom_range(10, 60);
         repeat (n) begin
            send_point(make_point(mode, pick_value(lo, hi), $urandom_range(0, 6) != 0));
         end
         sent += n;
         await_idle();
      end

      repeat (2 * PipeDepth) @(posedge clock);
      if (sb.errors == 0 && sb.expected_colours.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Guard against a hung handshake
   initial begin
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/scm_pkg.sv
hw/rtl/scm_csr.sv
hw/rtl/scm_front.sv
hw/rtl/scm_divider.sv
hw/rtl/scm_colour.sv
hw/rtl/scalar_to_colour_map_core.sv
tb/testbench.sv
